/* rtl/brrs_pkg.sv */
`timescale 1ns / 1ps
package brrs_pkg;

  localparam int BANKS_DEF       = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int TIMER_W  = 10;
  localparam int WAKE_W   = 12;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [TIMER_W-1:0] ACCESS_LATENCY_RST = 10'd20;
  localparam logic [WAKE_W-1:0]  WAKE_LATENCY_RST   = 12'd400;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACCESS_LATENCY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_LATENCY   = 1'b1;

  // command codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DOWN = 2'd2;
  localparam logic [1:0] OP_UP   = 2'd3;

  // power modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_ACTIVE = 2'd1;
  localparam logic [1:0] MODE_DOWN   = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  target_bank;
    logic [7:0]  request_tag;
    logic [31:0] start_stamp;
  } in_word_t;

  typedef struct packed {
    logic        done_valid;
    logic [7:0]  done_tag;
    logic [31:0] done_latency;
    logic        dropped;
    logic [1:0]  mode_now;
    logic [7:0]  pending_total;
    logic [31:0] served_count;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/brrs_ram.sv */
`timescale 1ns / 1ps
module brrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // hold read data while no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bank_round_robin_request_server_top.sv */
`timescale 1ns / 1ps
// Round-robin bank request server.
// Input channel (in_valid / in_stall / in_data) carries one command word:
// tick, add request, power down or power up. Every accepted word yields
// exactly one result word on the output channel (out_valid / out_stall /
// out_data): completion tag and latency, drop flag, power mode, number of
// queued requests and the completion count.
// Each bank owns a FIFO in a shared queue RAM; fill, head and busy timer of
// all banks sit in a small metadata RAM, and the request in service of each
// bank in a third RAM. A word is accepted, its metadata is read, and then it is
// modified and written back as its result is loaded; a tick that moves a queue
// head into service passes through a further state in which the queue head is
// read out and written to the service RAM. One word is in work at a time, so a
// new word is accepted only once the previous one has finished its write-back.
// The result register lets a new word be accepted while the previous
// result waits; when the receiver stalls, the next word holds before its
// write-back until the result register frees up.
// Reset (rst_n low, synchronous) empties all queues, clears timers, the
// pointer, clocks and counters, and restores the power-up defaults of the
// configuration registers. No clearing pass is needed: per-bank valid bits
// make never-written metadata read as zero.
module bank_round_robin_request_server_top
  import brrs_pkg::*;
#(
  parameter int BANKS       = BANKS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int BW     = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int HW     = $clog2(QUEUE_DEPTH);
  localparam int FW     = $clog2(QUEUE_DEPTH + 1);
  localparam int QDEPTH = BANKS * QUEUE_DEPTH;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int PW     = $clog2(QDEPTH + 1);
  localparam int MW     = FW + HW + TIMER_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } state_t;

  state_t state_r, state_nxt;

  in_word_t            item_r;
  logic [BW-1:0]       bank_r;
  logic [1:0]          mode_r, mode_nxt;
  logic [WAKE_W-1:0]   wake_r, wake_nxt;
  logic [31:0]         clock_r, clock_nxt;
  logic [31:0]         served_r, served_nxt;
  logic [PW-1:0]       pending_r, pending_nxt;
  logic [BW-1:0]       ptr_r, ptr_nxt;
  logic [BANKS-1:0]    nonempty_r, nonempty_nxt;
  logic [BANKS-1:0]    meta_vld_r, meta_vld_nxt;
  logic [TIMER_W-1:0]  acc_lat_r;
  logic [WAKE_W-1:0]   wake_lat_r;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_data_r, out_data_nxt;

  logic                accept;
  logic                out_free;
  logic                out_load;
  logic [BW-1:0]       rd_bank;

  // metadata RAM: {fill, head, timer} per bank
  logic                meta_we;
  logic [MW-1:0]       meta_wdata;
  logic [MW-1:0]       meta_rdata;
  logic [FW-1:0]       m_fill;
  logic [HW-1:0]       m_head;
  logic [TIMER_W-1:0]  m_timer;

  // queue RAM
  logic                q_we;
  logic [QAW-1:0]      q_waddr;
  logic                q_re;
  logic [QAW-1:0]      q_raddr;
  logic [ENTRY_W-1:0]  q_rdata;
  logic [QAW-1:0]      q_base;

  // service RAM
  logic                svc_we;
  logic [ENTRY_W-1:0]  svc_rdata;
  entry_t              svc_entry;

  // per-command helpers
  logic [HW:0]         slot_sum;
  logic [HW-1:0]       slot;
  logic [HW-1:0]       head_inc;
  logic [FW-1:0]       fill_dec;
  logic [TIMER_W-1:0]  timer_dec;
  logic                bank_bad;

  // round-robin search
  logic [BANKS-1:0]    rr_ne;
  logic [BANKS-1:0]    rr_above;
  logic [BW-1:0]       rr_next;

  assign accept    = (state_r == ST_IDLE) && in_valid;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // adds look up the target bank, everything else the pointed bank
  assign rd_bank = (in_data.opcode == OP_ADD) ? BW'(in_data.target_bank) : ptr_r;

  brrs_ram #(.WIDTH(MW), .DEPTH(BANKS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (bank_r),
    .wdata (meta_wdata),
    .re    (accept),
    .raddr (rd_bank),
    .rdata (meta_rdata)
  );

  brrs_ram #(.WIDTH(ENTRY_W), .DEPTH(QDEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata ({item_r.request_tag, item_r.start_stamp}),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  brrs_ram #(.WIDTH(ENTRY_W), .DEPTH(BANKS)) u_svc_ram (
    .clk   (clk),
    .we    (svc_we),
    .waddr (bank_r),
    .wdata (q_rdata),
    .re    (accept),
    .raddr (rd_bank),
    .rdata (svc_rdata)
  );

  // a bank whose metadata was never written reads as empty and idle
  assign m_fill    = meta_vld_r[bank_r] ? meta_rdata[MW-1 -: FW] : '0;
  assign m_head    = meta_vld_r[bank_r] ? meta_rdata[TIMER_W +: HW] : '0;
  assign m_timer   = meta_vld_r[bank_r] ? meta_rdata[TIMER_W-1:0] : '0;
  assign svc_entry = entry_t'(svc_rdata);

  assign q_base    = QAW'(bank_r) * QAW'(QUEUE_DEPTH);
  assign slot_sum  = (HW+1)'(m_head) + (HW+1)'(m_fill);
  assign slot      = (slot_sum >= (HW+1)'(QUEUE_DEPTH)) ?
                     HW'(slot_sum - (HW+1)'(QUEUE_DEPTH)) : HW'(slot_sum);
  assign head_inc  = (m_head == HW'(QUEUE_DEPTH - 1)) ? '0 : m_head + 1'b1;
  assign fill_dec  = m_fill - 1'b1;
  assign timer_dec = m_timer - 1'b1;
  assign bank_bad  = int'(item_r.target_bank) >= BANKS;

  function automatic logic [BW-1:0] lowest_set(input logic [BANKS-1:0] v);
    logic [BW-1:0] idx;
    idx = '0;
    for (int i = BANKS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BW'(i);
      end
    end
    return idx;
  endfunction

  // next nonempty bank after the pointed one, wrapping; stay if none
  always_comb begin
    rr_ne         = nonempty_r;
    rr_ne[bank_r] = 1'b0;
    for (int i = 0; i < BANKS; i++) begin
      rr_above[i] = rr_ne[i] && (i > int'(bank_r));
    end
    if (|rr_above) begin
      rr_next = lowest_set(rr_above);
    end else if (|rr_ne) begin
      rr_next = lowest_set(rr_ne);
    end else begin
      rr_next = bank_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    wake_nxt      = wake_r;
    clock_nxt     = clock_r;
    served_nxt    = served_r;
    pending_nxt   = pending_r;
    ptr_nxt       = ptr_r;
    nonempty_nxt  = nonempty_r;
    meta_vld_nxt  = meta_vld_r;
    meta_we       = 1'b0;
    meta_wdata    = {m_fill, m_head, m_timer};
    q_we          = 1'b0;
    q_waddr       = q_base + QAW'(slot);
    q_re          = 1'b0;
    q_raddr       = q_base + QAW'(m_head);
    svc_we        = 1'b0;
    out_load      = 1'b0;
    out_data_nxt  = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        // hold the write-back until the result register can take the word
        if (out_free) begin
          state_nxt = ST_IDLE;
          out_load  = 1'b1;
          case (item_r.opcode)
            OP_TICK: begin
              clock_nxt = clock_r + 1'b1;
              if (mode_r == MODE_DOWN) begin
                // clock only
              end else if (mode_r == MODE_IDLE && wake_r != '0) begin
                wake_nxt = wake_r - 1'b1;
              end else begin
                if (m_timer == '0) begin
                  if (m_fill != '0) begin
                    // move the head into service; result follows the queue read
                    q_re                 = 1'b1;
                    out_load             = 1'b0;
                    state_nxt            = ST_LOAD;
                    meta_we              = 1'b1;
                    meta_wdata           = {fill_dec, head_inc, acc_lat_r};
                    nonempty_nxt[bank_r] = (fill_dec != '0);
                    pending_nxt          = pending_r - 1'b1;
                    mode_nxt             = MODE_ACTIVE;
                  end
                end else begin
                  meta_we    = 1'b1;
                  meta_wdata = {m_fill, m_head, timer_dec};
                  if (timer_dec == '0) begin
                    served_nxt                = served_r + 1'b1;
                    mode_nxt                  = MODE_IDLE;
                    out_data_nxt.done_valid   = 1'b1;
                    out_data_nxt.done_tag     = svc_entry.tag;
                    out_data_nxt.done_latency = clock_r - svc_entry.stamp;
                  end
                end
                ptr_nxt = rr_next;
              end
            end

            OP_ADD: begin
              if (bank_bad || m_fill >= FW'(QUEUE_DEPTH)) begin
                out_data_nxt.dropped = 1'b1;
              end else begin
                q_we                 = 1'b1;
                meta_we              = 1'b1;
                meta_wdata           = {m_fill + 1'b1, m_head, m_timer};
                nonempty_nxt[bank_r] = 1'b1;
                pending_nxt          = pending_r + 1'b1;
              end
            end

            OP_DOWN: begin
              mode_nxt = MODE_DOWN;
            end

            OP_UP: begin
              mode_nxt = MODE_IDLE;
              wake_nxt = wake_lat_r;
            end

            default: begin
              mode_nxt = mode_r;
            end
          endcase
          if (meta_we) begin
            meta_vld_nxt[bank_r] = 1'b1;
          end
        end
      end

      ST_LOAD: begin
        // queue head is on the read port: park it as the bank's request in service
        if (out_free) begin
          svc_we    = 1'b1;
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_data_nxt.mode_now      = mode_nxt;
    out_data_nxt.pending_total = 8'(pending_nxt);
    out_data_nxt.served_count  = served_nxt;

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_IDLE;
      wake_r      <= '0;
      clock_r     <= '0;
      served_r    <= '0;
      pending_r   <= '0;
      ptr_r       <= '0;
      nonempty_r  <= '0;
      meta_vld_r  <= '0;
      acc_lat_r   <= ACCESS_LATENCY_RST;
      wake_lat_r  <= WAKE_LATENCY_RST;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      wake_r      <= wake_nxt;
      clock_r     <= clock_nxt;
      served_r    <= served_nxt;
      pending_r   <= pending_nxt;
      ptr_r       <= ptr_nxt;
      nonempty_r  <= nonempty_nxt;
      meta_vld_r  <= meta_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (out_load) begin
        out_data_r <= out_data_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACCESS_LATENCY: acc_lat_r  <= cfg_wdata[TIMER_W-1:0];
          CFG_WAKE_LATENCY:   wake_lat_r <= cfg_wdata[WAKE_W-1:0];
          default:            acc_lat_r  <= acc_lat_r;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      bank_r <= rd_bank;
    end
  end

endmodule

/* tb/bank_round_robin_request_server_top_test.sv */
`timescale 1ns / 1ps
module bank_round_robin_request_server_top_test;
  import brrs_pkg::*;

  // Quiet cycles (no word accepted on either channel) before the run is abandoned.
  localparam int IDLE_LIMIT = 6000;
  localparam int PLAN_ROWS  = 13;

  // One row of the directed plan: a command word, how many times to issue it
  // (the tag advances by one on each repeat), and an optional typed-in result.
  typedef struct packed {
    in_word_t   cmd;
    logic [7:0] reps;
    logic       typed;
    out_word_t  want;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  bank_round_robin_request_server_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler image: bank queues, timers, pointer and power state, kept at the
  // widths of the block so that heads, pointers and clocks wrap the same way.
  // ---------------------------------------------------------------------------
  logic [7:0]  q_tag     [BANKS_DEF][QUEUE_DEPTH_DEF];
  logic [31:0] q_stamp   [BANKS_DEF][QUEUE_DEPTH_DEF];
  logic [4:0]  bank_fill [BANKS_DEF];
  logic [3:0]  bank_head [BANKS_DEF];
  logic [9:0]  busy_left [BANKS_DEF];
  logic [7:0]  svc_tag   [BANKS_DEF];
  logic [31:0] svc_stamp [BANKS_DEF];
  logic [2:0]  rr_ptr;
  logic [1:0]  pwr_mode;
  logic [11:0] wake_left;
  logic [31:0] tick_count;
  logic [31:0] served;
  logic [9:0]  access_lat;
  logic [11:0] wake_lat;

  out_word_t due_results [$];
  int        errors = 0;
  bit        calm = 1'b0;
  int        stall_left = 0;
  int        quiet_cycles = 0;

  // Compute the result word of one command and advance the scheduler image.
  function automatic out_word_t serve_command(input in_word_t w);
    out_word_t  r;
    logic [2:0] p;
    logic [2:0] cand;
    logic [2:0] nxt;
    logic [3:0] slot;
    logic [7:0] sum;
    bit         found;
    r = '0;
    case (w.opcode)
      OP_TICK: begin
        if (pwr_mode == MODE_DOWN) begin
          // powered down: only the clock moves
          tick_count++;
        end else if (pwr_mode == MODE_IDLE && wake_left != 0) begin
          // still waking up: burn one tick of the wake delay
          wake_left--;
          tick_count++;
        end else begin
          p = rr_ptr;
          if (busy_left[p] == 0) begin
            // bank free: pull the queue head into service
            if (bank_fill[p] != 0) begin
              svc_tag[p]   = q_tag[p][bank_head[p]];
              svc_stamp[p] = q_stamp[p][bank_head[p]];
              bank_head[p]++;
              bank_fill[p]--;
              busy_left[p] = access_lat;
              pwr_mode     = MODE_ACTIVE;
            end
          end else begin
            busy_left[p]--;
            if (busy_left[p] == 0) begin
              r.done_valid   = 1'b1;
              r.done_tag     = svc_tag[p];
              r.done_latency = tick_count - svc_stamp[p];
              served++;
              pwr_mode = MODE_IDLE;
            end
          end
          // advance to the next bank with work queued, else stay put
          nxt   = p;
          found = 1'b0;
          for (int i = 1; i < BANKS_DEF; i++) begin
            cand = p + 3'(i);
            if (!found && bank_fill[cand] != 0) begin
              nxt   = cand;
              found = 1'b1;
            end
          end
          rr_ptr = nxt;
          tick_count++;
        end
      end
      OP_ADD: begin
        if (bank_fill[w.target_bank] >= QUEUE_DEPTH_DEF) begin
          r.dropped = 1'b1;
        end else begin
          slot = bank_head[w.target_bank] + bank_fill[w.target_bank][3:0];
          q_tag[w.target_bank][slot]   = w.request_tag;
          q_stamp[w.target_bank][slot] = w.start_stamp;
          bank_fill[w.target_bank]++;
        end
      end
      OP_DOWN: pwr_mode = MODE_DOWN;
      OP_UP: begin
        // wake from any mode restarts the wake delay
        pwr_mode  = MODE_IDLE;
        wake_left = wake_lat;
      end
    endcase
    sum = '0;
    for (int b = 0; b < BANKS_DEF; b++) sum += {3'b000, bank_fill[b]};
    r.mode_now      = pwr_mode;
    r.pending_total = sum;
    r.served_count  = served;
    return r;
  endfunction

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random command: add_pct percent adds, a few power commands, the rest ticks.
  function automatic in_word_t make_command(input int add_pct, input int bank_hi);
    in_word_t w;
    int       r;
    r = $urandom_range(0, 99);
    if (r < add_pct)          w.opcode = OP_ADD;
    else if (r < add_pct + 4) w.opcode = OP_DOWN;
    else if (r < add_pct + 8) w.opcode = OP_UP;
    else                      w.opcode = OP_TICK;
    w.target_bank = 3'($urandom_range(0, bank_hi));
    w.request_tag = 8'($urandom);
    // stamps near the clock give plain latencies, raw ones exercise the wrap
    if ($urandom_range(0, 1) == 0) w.start_stamp = tick_count - 32'($urandom_range(0, 60));
    else                           w.start_stamp = $urandom;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (due_results.size() == 0) begin
      $display("%0t: result word with none due, got %0h", $time, got);
      errors++;
    end else begin
      want = due_results.pop_front();
      check_field("done_valid",    32'(want.done_valid),    32'(got.done_valid));
      check_field("done_tag",      32'(want.done_tag),      32'(got.done_tag));
      check_field("done_latency",  want.done_latency,       got.done_latency);
      check_field("dropped",       32'(want.dropped),       32'(got.dropped));
      check_field("mode_now",      32'(want.mode_now),      32'(got.mode_now));
      check_field("pending_total", 32'(want.pending_total), 32'(got.pending_total));
      check_field("served_count",  want.served_count,       got.served_count);
    end
  endtask

  // Offer one command word and hold it until accepted, then queue its result.
  // Leave valid high when no gap follows so the next word goes out back to back.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    int gap;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    if (typed) begin
      void'(serve_command(w));
      due_results.push_back(want);
    end else begin
      due_results.push_back(serve_command(w));
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write both registers on consecutive edges; the block is idle here.
  task automatic load_settings(input logic [9:0] acc, input logic [11:0] wake);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ACCESS_LATENCY;
    cfg_wdata <= {2'b00, acc};
    @(posedge clk);
    cfg_index <= CFG_WAKE_LATENCY;
    cfg_wdata <= wake;
    @(posedge clk);
    cfg_we     <= 1'b0;
    access_lat = acc;
    wake_lat   = wake;
  endtask

  // Drain, reprogram, then issue n random commands; optionally pause midway
  // until every due result has come back.
  task automatic run_phase(input logic [9:0] acc, input logic [11:0] wake, input int n,
                           input int add_pct, input int bank_hi, input bit calm_in,
                           input bit pause_mid);
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    load_settings(acc, wake);
    calm = calm_in;
    for (int i = 0; i < n; i++) begin
      send_word(make_command(add_pct, bank_hi), 1'b0, '0);
      if (pause_mid && i == n / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (due_results.size() != 0);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: check accepted words, stall in random bursts.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  // Watchdog: abandon the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("bank_round_robin_request_server_top_test NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin
    plan_row_t plan [PLAN_ROWS];
    plan_row_t row;
    in_word_t  w;

    // Reset image of the scheduler, with the power-up register defaults.
    for (int b = 0; b < BANKS_DEF; b++) begin
      bank_fill[b] = '0;
      bank_head[b] = '0;
      busy_left[b] = '0;
      svc_tag[b]   = '0;
      svc_stamp[b] = '0;
      for (int s = 0; s < QUEUE_DEPTH_DEF; s++) begin
        q_tag[b][s]   = '0;
        q_stamp[b][s] = '0;
      end
    end
    rr_ptr     = '0;
    pwr_mode   = MODE_IDLE;
    wake_left  = '0;
    tick_count = '0;
    served     = '0;
    access_lat = ACCESS_LATENCY_RST;
    wake_lat   = WAKE_LATENCY_RST;

    // Directed plan, run with the reset register values. Typed results are the
    // ones obvious from the reset state; the rest come from the image.
    plan = '{
      // tick right after reset: nothing queued, nothing served
      '{'{OP_TICK, 3'd0, 8'h00, 32'h0000_0000}, 8'd1, 1'b1,
        '{1'b0, 8'h00, 32'h0, 1'b0, MODE_IDLE, 8'd0, 32'd0}},
      // extreme tag and stamp into bank 0, so its latency wraps
      '{'{OP_ADD, 3'd0, 8'hFF, 32'hFFFF_FFFF}, 8'd1, 1'b1,
        '{1'b0, 8'h00, 32'h0, 1'b0, MODE_IDLE, 8'd1, 32'd0}},
      '{'{OP_ADD, 3'd7, 8'h00, 32'h0000_0000}, 8'd1, 1'b1,
        '{1'b0, 8'h00, 32'h0, 1'b0, MODE_IDLE, 8'd2, 32'd0}},
      // fill bank 3 to the brim
      '{'{OP_ADD, 3'd3, 8'h5A, 32'h1234_5678}, 8'd16, 1'b0, '0},
      // full queue: the add is dropped
      '{'{OP_ADD, 3'd3, 8'hA5, 32'h0000_0000}, 8'd1, 1'b1,
        '{1'b0, 8'h00, 32'h0, 1'b1, MODE_IDLE, 8'd18, 32'd0}},
      // serve: starts, countdowns and completions
      '{'{OP_TICK, 3'd5, 8'h3C, 32'hDEAD_BEEF}, 8'd45, 1'b0, '0},
      // wake while active or idle
      '{'{OP_UP, 3'd2, 8'h11, 32'h0000_0001}, 8'd1, 1'b0, '0},
      '{'{OP_TICK, 3'd1, 8'h22, 32'h8000_0000}, 8'd3, 1'b0, '0},
      '{'{OP_DOWN, 3'd6, 8'h33, 32'h7FFF_FFFF}, 8'd1, 1'b0, '0},
      '{'{OP_TICK, 3'd4, 8'h44, 32'h0000_00FF}, 8'd2, 1'b0, '0},
      // wake from power down
      '{'{OP_UP, 3'd0, 8'h55, 32'h0000_0000}, 8'd1, 1'b0, '0},
      '{'{OP_TICK, 3'd7, 8'h66, 32'hFFFF_0000}, 8'd2, 1'b0, '0},
      // leave it powered down; the next phase wakes it with a short delay
      '{'{OP_DOWN, 3'd3, 8'h77, 32'h0000_FFFF}, 8'd1, 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = plan[i];
      for (int k = 0; k < row.reps; k++) begin
        w = row.cmd;
        w.request_tag = row.cmd.request_tag + 8'(k);
        send_word(w, row.typed, row.want);
      end
    end
    in_valid <= 1'b0;

    // Random phases: latency, wake delay, count, add share, bank span, calm, pause.
    run_phase(10'd3,    12'd5,    110, 30, 7, 1'b0, 1'b1);
    run_phase(10'd1,    12'd0,    80,  35, 7, 1'b1, 1'b0);
    // zero access latency: requests never complete and get overwritten
    run_phase(10'd0,    12'd2,    60,  35, 7, 1'b0, 1'b0);
    run_phase(10'd1023, 12'd4095, 40,  30, 7, 1'b0, 1'b0);
    // flood two banks so queues fill and adds get dropped
    run_phase(10'd6,    12'd9,    130, 70, 1, 1'b0, 1'b1);
    run_phase(10'd20,   12'd400,  60,  30, 7, 1'b1, 1'b0);

    // Drain, then give any stray word time to show up.
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("bank_round_robin_request_server_top_test OK");
    end else begin
      $display("bank_round_robin_request_server_top_test NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/brrs_pkg.sv
rtl/brrs_ram.sv
rtl/bank_round_robin_request_server_top.sv
tb/bank_round_robin_request_server_top_test.sv
